// ===== src/nnact_pkg.sv =====
// ============================================================================
// nnact_pkg: shared definitions for the activation unit
// Activation function codes, configuration register indexes and the default
// values of the top-level parameters.
// ============================================================================
package nnact_pkg;

	// Default geometry: Q4.12 data and a 256-entry sigmoid curve table.
	localparam int DATA_WIDTH_DEFAULT          = 16;
	localparam int FRAC_BITS_DEFAULT           = 12;
	localparam int CURVE_TABLE_ENTRIES_DEFAULT = 256;

	// Configuration port geometry.
	localparam int CFG_INDEX_WIDTH = 4;
	localparam int CFG_DATA_WIDTH  = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HIDDEN_FUNCTION = CFG_INDEX_WIDTH'(0);
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OUTPUT_FUNCTION = CFG_INDEX_WIDTH'(1);

	// Activation function codes; all four codes of the register are defined.
	typedef enum logic [CFG_DATA_WIDTH-1:0] {
		ACT_SIGMOID = 2'd0,
		ACT_TANH    = 2'd1,
		ACT_RELU    = 2'd2,
		ACT_LINEAR  = 2'd3
	} act_fn_t;

endpackage

// ===== src/nn_activation_unit.sv =====
// ============================================================================
// nn_activation_unit: fixed-point neural-network activation unit
// Applies sigmoid, tanh, relu or linear (slope 3.14) to a signed fixed-point
// item, or the derivative of that function, and saturates the result.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  ------------------------------------
//  input     in_valid / in_stall        operand, want_derivative,
//                                       use_output_layer
//  output    out_valid / out_stall      result_value, clipped
//  config    cfg_write_enable           cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; each item passes from the
// input register to the result register before it is presented on the output. The
// path from the input register through the single multiplier (or the curve table)
// and the saturation logic to the result register sets the clock rate.
// Reset clears both function registers to sigmoid and empties both stages.
// A stall on the output holds the result register; the input register still
// takes one more item, and the input stalls only once both stages are full.
//
module nn_activation_unit
	import nnact_pkg::*;
#(
	parameter int DATA_WIDTH          = DATA_WIDTH_DEFAULT,
	parameter int FRAC_BITS           = FRAC_BITS_DEFAULT,
	parameter int CURVE_TABLE_ENTRIES = CURVE_TABLE_ENTRIES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [DATA_WIDTH-1:0]      operand,
	input  logic                              want_derivative,
	input  logic                              use_output_layer,
	// Configuration port
	input  logic                              cfg_write_enable,
	input  logic        [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic        [CFG_DATA_WIDTH-1:0]  cfg_data,
	// Output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [DATA_WIDTH-1:0]      result_value,
	output logic                              clipped
);

	// ------------------------------------------------------------------------
	// Derived constants
	// ------------------------------------------------------------------------
	localparam longint ONE_L   = longint'(1) << FRAC_BITS;
	localparam longint SLOPE_L = (314 * ONE_L + 50) / 100;
	localparam longint DMAX_L  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
	localparam longint DMIN_L  = -DMAX_L - 1;

	// Multiplier second operand: holds ONE - x, x or the slope constant.
	localparam int BW = (DATA_WIDTH + 1 > FRAC_BITS + 3) ? DATA_WIDTH + 1 : FRAC_BITS + 3;
	localparam int PW = DATA_WIDTH + BW;
	localparam int RW = PW + 1;

	// Curve table addressing.
	localparam int AW = DATA_WIDTH + 1;
	localparam int NW = $clog2(CURVE_TABLE_ENTRIES + 1);
	localparam int SW = AW + NW;
	localparam int IW = $clog2(CURVE_TABLE_ENTRIES);
	localparam int CW = FRAC_BITS + 1;

	localparam logic signed [DATA_WIDTH-1:0] DATA_MAX_V = DATA_WIDTH'(DMAX_L);
	localparam logic signed [DATA_WIDTH-1:0] DATA_MIN_V = DATA_WIDTH'(DMIN_L);
	localparam logic signed [RW-1:0]         DMAX_R     = RW'(DMAX_L);
	localparam logic signed [RW-1:0]         DMIN_R     = RW'(DMIN_L);
	localparam logic signed [RW-1:0]         ONE_R      = RW'(ONE_L);
	localparam logic signed [RW-1:0]         SLOPE_R    = RW'(SLOPE_L);
	localparam logic signed [BW-1:0]         ONE_B      = BW'(ONE_L);
	localparam logic signed [BW-1:0]         SLOPE_B    = BW'(SLOPE_L);
	localparam logic [SW-1:0]                IDX_LAST_S = SW'(CURVE_TABLE_ENTRIES - 1);
	localparam logic [IW-1:0]                IDX_LAST   = IW'(CURVE_TABLE_ENTRIES - 1);

	// ------------------------------------------------------------------------
	// Sigmoid curve table: piecewise-linear sigmoid at each entry's left edge
	// over magnitudes from 0 up to 8.
	// ------------------------------------------------------------------------
	logic [CW-1:0] curve_rom [CURVE_TABLE_ENTRIES];

	for (genvar gi = 0; gi < CURVE_TABLE_ENTRIES; gi++) begin : g_curve
		localparam longint EDGE  = (longint'(gi) << (FRAC_BITS + 3)) / CURVE_TABLE_ENTRIES;
		localparam longint ENTRY =
			(EDGE >= 5 * ONE_L)        ? ONE_L :
			(EDGE >= (19 * ONE_L) / 8) ? (EDGE >> 5) + (27 * ONE_L) / 32 :
			(EDGE >= ONE_L)            ? (EDGE >> 3) + (5 * ONE_L) / 8 :
			                             (EDGE >> 2) + ONE_L / 2;
		assign curve_rom[gi] = CW'(ENTRY);
	end

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	act_fn_t hidden_function_q;
	act_fn_t output_function_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_function_q <= ACT_SIGMOID;
			output_function_q <= ACT_SIGMOID;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				CFG_HIDDEN_FUNCTION: hidden_function_q <= act_fn_t'(cfg_data);
				CFG_OUTPUT_FUNCTION: output_function_q <= act_fn_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Flow control: each stage moves on when it is empty or its successor
	// moves on.
	// ------------------------------------------------------------------------
	logic valid_s1;
	logic valid_q;
	logic out_free;
	logic s1_free;
	logic in_accept;

	assign out_free  = !valid_q || !out_stall;
	assign s1_free   = !valid_s1 || out_free;
	assign in_stall  = !s1_free;
	assign in_accept = in_valid && s1_free;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_q <= valid_s1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Input register; the function is chosen from the layer flag on entry.
	// ------------------------------------------------------------------------
	logic signed [DATA_WIDTH-1:0] operand_s1;
	logic                         deriv_s1;
	act_fn_t                      mode_s1;

	always_ff @(posedge clk) begin
		if (in_accept) begin
			operand_s1 <= operand;
			deriv_s1   <= want_derivative;
			mode_s1    <= use_output_layer ? output_function_q : hidden_function_q;
		end
	end

	// ------------------------------------------------------------------------
	// Curve table lookup: sigmoid reads at |x|, tanh at 2|x|.
	// ------------------------------------------------------------------------
	logic                  x_neg;
	logic [DATA_WIDTH-1:0] mag;
	logic [AW-1:0]         curve_arg;
	logic [SW-1:0]         curve_scaled;
	logic [SW-1:0]         idx_wide;
	logic [IW-1:0]         curve_idx;
	logic [CW-1:0]         curve_p;

	assign x_neg        = operand_s1[DATA_WIDTH-1];
	assign mag          = x_neg ? DATA_WIDTH'(-operand_s1) : DATA_WIDTH'(operand_s1);
	assign curve_arg    = (mode_s1 == ACT_TANH) ? {mag, 1'b0} : {1'b0, mag};
	assign curve_scaled = SW'(curve_arg) * SW'(CURVE_TABLE_ENTRIES);
	assign idx_wide     = curve_scaled >> (FRAC_BITS + 3);
	assign curve_idx    = (idx_wide > IDX_LAST_S) ? IDX_LAST : idx_wide[IW-1:0];
	assign curve_p      = curve_rom[curve_idx];

	// ------------------------------------------------------------------------
	// Shared multiplier: s*(ONE-s), t*t or x*slope, floored by the fraction.
	// ------------------------------------------------------------------------
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] product;
	logic signed [RW-1:0] prod_sh;

	always_comb begin
		mul_b = SLOPE_B;
		case (mode_s1)
			ACT_SIGMOID: mul_b = ONE_B - BW'(operand_s1);
			ACT_TANH:    mul_b = BW'(operand_s1);
			ACT_RELU:    mul_b = SLOPE_B;
			ACT_LINEAR:  mul_b = SLOPE_B;
		endcase
	end

	assign product = PW'(operand_s1) * PW'(mul_b);
	assign prod_sh = RW'(product >>> FRAC_BITS);

	// ------------------------------------------------------------------------
	// Result selection and saturation.
	// ------------------------------------------------------------------------
	logic signed [RW-1:0]         x_r;
	logic signed [RW-1:0]         p_r;
	logic signed [RW-1:0]         tanh_t;
	logic signed [RW-1:0]         raw_r;
	logic                         x_pos;
	logic signed [DATA_WIDTH-1:0] sat_value;
	logic                         sat_clip;

	assign x_r    = RW'(operand_s1);
	assign p_r    = signed'(RW'(curve_p));
	assign tanh_t = (p_r <<< 1) - ONE_R;
	assign x_pos  = !x_neg && (operand_s1 != '0);

	always_comb begin
		raw_r = '0;
		if (!deriv_s1) begin
			case (mode_s1)
				ACT_SIGMOID: raw_r = x_neg ? ONE_R - p_r : p_r;
				ACT_TANH:    raw_r = x_neg ? -tanh_t : tanh_t;
				ACT_RELU:    raw_r = x_pos ? x_r : '0;
				ACT_LINEAR:  raw_r = prod_sh;
			endcase
		end else begin
			case (mode_s1)
				ACT_SIGMOID: raw_r = prod_sh;
				ACT_TANH:    raw_r = ONE_R - prod_sh;
				ACT_RELU:    raw_r = x_pos ? ONE_R : '0;
				ACT_LINEAR:  raw_r = SLOPE_R;
			endcase
		end
	end

	always_comb begin
		if (raw_r > DMAX_R) begin
			sat_value = DATA_MAX_V;
			sat_clip  = 1'b1;
		end else if (raw_r < DMIN_R) begin
			sat_value = DATA_MIN_V;
			sat_clip  = 1'b1;
		end else begin
			sat_value = raw_r[DATA_WIDTH-1:0];
			sat_clip  = 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------------
	logic signed [DATA_WIDTH-1:0] result_q;
	logic                         clipped_q;

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			result_q  <= sat_value;
			clipped_q <= sat_clip;
		end
	end

	assign result_value = result_q;
	assign clipped      = clipped_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
	// A saturated result sits at one end of the data range.
	a_clip_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && clipped_q) |-> (result_q == DATA_MAX_V || result_q == DATA_MIN_V))
		else $error("clipped result is not at a range limit");

	// An item in the input register moves to the output when the output is free.
	a_s1_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_free) |=> valid_q)
		else $error("item lost between input register and result register");

	// A blocked item in the input register is held unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(operand_s1) && $stable(mode_s1)))
		else $error("blocked item in input register changed");

	// The input stalls only when both stages hold an item.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_q && out_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule
